// ----- hw/rtl/lkv_pkg.sv -----
// ----------------------------------------------------------------------------
// LRU key-value cache package
// Shared widths, operation codes and request/response types.
// ----------------------------------------------------------------------------
package lkv_pkg;

   localparam int KeyBits        = 16;
   localparam int ValueBits      = 16;
   localparam int CapBits        = 5;
   localparam int EntriesDefault = 16;

   localparam logic [CapBits-1:0] CAP_RESET = CapBits'(16);

   localparam logic KIND_GET = 1'b0;
   localparam logic KIND_PUT = 1'b1;

   typedef struct packed {
      logic                 kind;
      logic [KeyBits-1:0]   key;
      logic [ValueBits-1:0] write_value;
   } lkv_req_type;

   typedef struct packed {
      logic                 hit;
      logic [ValueBits-1:0] read_value;
   } lkv_rsp_type;

   typedef struct packed {
      logic hit;
      logic full;
   } lkv_look_type;

endpackage

// ----- hw/rtl/lkv_lookup.sv -----
// ----------------------------------------------------------------------------
// LRU cache lookup
// Parallel key compare, free-slot pick, LRU victim pick and capacity check.
// ----------------------------------------------------------------------------
module lkv_lookup #(
   parameter int Entries  = lkv_pkg::EntriesDefault,
   parameter int RankBits = (Entries > 1) ? $clog2(Entries) : 1,
   parameter int CntBits  = $clog2(Entries + 1)
) (
   input  logic [lkv_pkg::KeyBits-1:0]   key_i,
   input  logic [lkv_pkg::KeyBits-1:0]   keys_i   [Entries],
   input  logic [lkv_pkg::ValueBits-1:0] vals_i   [Entries],
   input  logic [RankBits-1:0]           ranks_i  [Entries],
   input  logic [Entries-1:0]            valid_i,
   input  logic [CntBits-1:0]            occ_i,
   input  logic [lkv_pkg::CapBits-1:0]   cap_i,
   output logic [Entries-1:0]            match_o,
   output logic [Entries-1:0]            free_o,
   output logic [Entries-1:0]            victim_o,
   output logic [RankBits-1:0]           hit_rank_o,
   output logic [lkv_pkg::ValueBits-1:0] hit_value_o,
   output lkv_pkg::lkv_look_type         look_o
);
   import lkv_pkg::*;

   localparam int CmpBits = (CntBits > CapBits) ? CntBits : CapBits;

   logic [CntBits-1:0] occ_m1;
   logic [CmpBits-1:0] cap_eff;
   logic               seen;

   assign occ_m1 = occ_i - CntBits'(1);

   always_comb begin
      seen        = 1'b0;
      hit_rank_o  = '0;
      hit_value_o = '0;
      for (int i = 0; i < Entries; i++) begin
         match_o[i]  = valid_i[i] && (keys_i[i] == key_i);
         hit_rank_o  = hit_rank_o | ({RankBits{match_o[i]}} & ranks_i[i]);
         hit_value_o = hit_value_o | ({ValueBits{match_o[i]}} & vals_i[i]);
         // lowest empty slot
         free_o[i]   = !valid_i[i] && !seen;
         seen        = seen | !valid_i[i];
         // ranks of valid entries form 0..occ-1, so the oldest holds occ-1
         victim_o[i] = valid_i[i] && (CntBits'(ranks_i[i]) == occ_m1);
      end
   end

   always_comb begin
      if (cap_i == '0) begin
         cap_eff = CmpBits'(1);
      end else if (CmpBits'(cap_i) > CmpBits'(Entries)) begin
         cap_eff = CmpBits'(Entries);
      end else begin
         cap_eff = CmpBits'(cap_i);
      end
      look_o.hit  = |match_o;
      look_o.full = CmpBits'(occ_i) >= cap_eff;
   end

endmodule

// ----- hw/rtl/lkv_store.sv -----
// ----------------------------------------------------------------------------
// LRU cache store
// Entry registers, age ranks and occupancy with their single-pass update.
// ----------------------------------------------------------------------------
module lkv_store #(
   parameter int Entries  = lkv_pkg::EntriesDefault,
   parameter int RankBits = (Entries > 1) ? $clog2(Entries) : 1,
   parameter int CntBits  = $clog2(Entries + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          op_vld_i,
   input  lkv_pkg::lkv_req_type          op_i,
   input  logic [lkv_pkg::CapBits-1:0]   cap_i,
   output lkv_pkg::lkv_rsp_type          rsp_o
);
   import lkv_pkg::*;

   logic [KeyBits-1:0]   keys_ff  [Entries];
   logic [ValueBits-1:0] vals_ff  [Entries];
   logic [RankBits-1:0]  ranks_ff [Entries];
   logic [Entries-1:0]   valid_ff;
   logic [CntBits-1:0]   occ_ff;
   logic [CntBits-1:0]   occ_in;

   logic [Entries-1:0]   match;
   logic [Entries-1:0]   free;
   logic [Entries-1:0]   victim;
   logic [RankBits-1:0]  hit_rank;
   logic [ValueBits-1:0] hit_value;
   lkv_look_type         look;

   logic                 is_put;
   logic                 touch;
   logic                 insert;
   logic [Entries-1:0]   tgt;
   logic [CntBits-1:0]   age_lim;

   lkv_lookup #(
      .Entries  (Entries),
      .RankBits (RankBits),
      .CntBits  (CntBits)
   ) u_lookup (
      .key_i       (op_i.key),
      .keys_i      (keys_ff),
      .vals_i      (vals_ff),
      .ranks_i     (ranks_ff),
      .valid_i     (valid_ff),
      .occ_i       (occ_ff),
      .cap_i       (cap_i),
      .match_o     (match),
      .free_o      (free),
      .victim_o    (victim),
      .hit_rank_o  (hit_rank),
      .hit_value_o (hit_value),
      .look_o      (look)
   );

   always_comb begin
      is_put = (op_i.kind == KIND_PUT);
      touch  = op_vld_i && (look.hit || is_put);
      insert = op_vld_i && is_put && !look.hit;
      if (look.hit) begin
         tgt     = match;
         age_lim = CntBits'(hit_rank);
      end else if (look.full) begin
         tgt     = victim;
         age_lim = occ_ff - CntBits'(1);
      end else begin
         // fresh insert ages every valid entry
         tgt     = free;
         age_lim = occ_ff;
      end
      occ_in = occ_ff;
      if (insert && !look.full) begin
         occ_in = occ_ff + CntBits'(1);
      end
      rsp_o.hit        = look.hit;
      rsp_o.read_value = (look.hit && !is_put) ? hit_value : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         occ_ff   <= '0;
      end else begin
         occ_ff <= occ_in;
         if (insert) begin
            valid_ff <= valid_ff | tgt;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < Entries; i++) begin
         if (op_vld_i && is_put && tgt[i]) begin
            vals_ff[i] <= op_i.write_value;
         end
         if (insert && tgt[i]) begin
            keys_ff[i] <= op_i.key;
         end
         if (touch) begin
            if (tgt[i]) begin
               ranks_ff[i] <= '0;
            end else if (valid_ff[i] && (CntBits'(ranks_ff[i]) < age_lim)) begin
               ranks_ff[i] <= ranks_ff[i] + RankBits'(1);
            end
         end
      end
   end

endmodule

// ----- hw/rtl/lru_key_value_cache_top.sv -----
// ----------------------------------------------------------------------------
// LRU key-value cache
// Fully associative key-value store with least-recently-used replacement.
// ----------------------------------------------------------------------------
//  channel   | ports                        | handshake
//  request   | start, busy, req_data        | taken when start && !busy
//  response  | rsp_strobe, rsp_data         | one cycle, no back-pressure
//  control   | csr_we, csr_wdata (capacity) | written when csr_we
//
// One request per cycle: busy stays low. A request is registered at its
// accept edge, looked up and applied to the store in the next cycle, and its
// response is registered and shows on the strobe in the cycle after that.
// The lookup and rank update for all entries run in that same cycle.
// Reset clears the valid marks, occupancy and pipeline; capacity goes to 16.
// ----------------------------------------------------------------------------
module lru_key_value_cache_top #(
   parameter int Entries = lkv_pkg::EntriesDefault
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  lkv_pkg::lkv_req_type        req_data,
   output logic                        rsp_strobe,
   output lkv_pkg::lkv_rsp_type        rsp_data,
   input  logic                        csr_we,
   input  logic [lkv_pkg::CapBits-1:0] csr_wdata
);
   import lkv_pkg::*;

   logic                req_vld_ff;
   lkv_req_type         req_ff;
   logic [CapBits-1:0]  cap_ff;
   logic                rsp_vld_ff;
   lkv_rsp_type         rsp_ff;
   lkv_rsp_type         rsp_in;

   assign busy = 1'b0;

   lkv_store #(
      .Entries (Entries)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .op_vld_i (req_vld_ff),
      .op_i     (req_ff),
      .cap_i    (cap_ff),
      .rsp_o    (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
         cap_ff     <= CAP_RESET;
      end else begin
         req_vld_ff <= start && !busy;
         rsp_vld_ff <= req_vld_ff;
         if (csr_we) begin
            cap_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_data;
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_vld_ff;
   assign rsp_data   = rsp_ff;

endmodule

// ----- hw/rtl/lkv_checker.sv -----
// ----------------------------------------------------------------------------
// LRU cache port checker
// Timing and response rules seen on the top-level ports.
// ----------------------------------------------------------------------------
module lkv_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input lkv_pkg::lkv_req_type req_data,
   input logic                 rsp_strobe,
   input lkv_pkg::lkv_rsp_type rsp_data
);
   import lkv_pkg::*;

   logic acc;
   assign acc = start && !busy;

   // every accepted request is answered by a response strobe
   a_rsp_follows_req: assert property (@(posedge clock) disable iff (reset)
      acc |=> ##1 rsp_strobe)
      else $error("request not answered two cycles after accept");

   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(acc, 2))
      else $error("response without a request");

   a_put_reads_zero: assert property (@(posedge clock) disable iff (reset)
      acc && (req_data.kind == KIND_PUT) |=> ##1 (rsp_data.read_value == '0))
      else $error("put response carries a value");

   // a get right after a put of the same key must hit with the new value
   a_put_then_get: assert property (@(posedge clock) disable iff (reset)
      acc && (req_data.kind == KIND_GET) && $past(!reset)
      && $past(acc && (req_data.kind == KIND_PUT))
      && (req_data.key == $past(req_data.key))
      |=> ##1 (rsp_data.hit && (rsp_data.read_value == $past(req_data.write_value, 3))))
      else $error("get after put of same key missed or returned a stale value");

endmodule

bind lru_key_value_cache_top lkv_checker u_lkv_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_data   (req_data),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);

// ----- tb/sv/lru_key_value_cache_top_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LRU key-value cache testbench
// Drives get/put requests in random bursts across a series of capacity
// settings, predicts every response with a behavioral LRU store kept in the
// bench, and compares each strobed response field by field in arrival order.
// ----------------------------------------------------------------------------
module lru_key_value_cache_top_tb;

   import lkv_pkg::*;

   localparam int ENTRIES       = EntriesDefault;
   localparam int SETTLE_CYCLES = 4;
   localparam int STALL_LIMIT   = 1000;

   typedef enum logic [1:0] {
      STEP_REQUEST,
      STEP_DRAIN,
      STEP_CONFIG
   } step_kind_type;

   typedef struct {
      step_kind_type      kind;
      lkv_req_type        req;
      logic [CapBits-1:0] cap;
   } cache_step_type;

   logic               clock     = 1'b0;
   logic               reset     = 1'b1;
   logic               start     = 1'b0;
   logic               busy;
   lkv_req_type        req_data  = '0;
   logic               rsp_strobe;
   lkv_rsp_type        rsp_data;
   logic               csr_we    = 1'b0;
   logic [CapBits-1:0] csr_wdata = '0;

   cache_step_type cache_steps[$];
   lkv_rsp_type    predicted_replies[$];
   logic           quiet = 1'b1;

   // behavioral copy of the store
   logic [KeyBits-1:0]   cache_key   [ENTRIES];
   logic [ValueBits-1:0] cache_value [ENTRIES];
   bit                   cache_valid [ENTRIES];
   int unsigned          cache_rank  [ENTRIES];
   int unsigned          cache_fill;
   logic [CapBits-1:0]   cache_cap;

   int n_errors   = 0;
   int n_checked  = 0;
   int n_gets     = 0;
   int n_puts     = 0;
   int n_hits     = 0;
   int n_cfg      = 0;
   int burst_left = 1;
   int gap_left   = 0;
   int settle_cnt = 0;
   int stall_cycles = 0;

   lru_key_value_cache_top uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Make entry idx most recent; entries younger than its old rank age by one.
   function automatic void promote_entry(int idx, int unsigned old_rank);
      for (int i = 0; i < ENTRIES; i++) begin
         if (cache_valid[i] && i != idx && cache_rank[i] < old_rank) begin
            cache_rank[i]++;
         end
      end
      cache_rank[idx] = 0;
   endfunction

   function automatic lkv_rsp_type cache_access(lkv_req_type req);
      lkv_rsp_type rsp;
      int          found;
      int          slot;
      int          victim;
      int unsigned worst;
      int unsigned limit;
      rsp    = '0;
      found  = -1;
      slot   = -1;
      victim = -1;
      worst  = 0;
      limit  = (cache_cap == 0) ? 1 : (cache_cap > ENTRIES) ? ENTRIES : cache_cap;
      for (int i = 0; i < ENTRIES; i++) begin
         if (found < 0 && cache_valid[i] && cache_key[i] == req.key) begin
            found = i;
         end
      end
      if (found >= 0) begin
         rsp.hit = 1'b1;
         if (req.kind == KIND_GET) begin
            rsp.read_value = cache_value[found];
         end else begin
            cache_value[found] = req.write_value;
         end
         promote_entry(found, cache_rank[found]);
      end else if (req.kind == KIND_PUT) begin
         if (cache_fill >= limit) begin
            // evict the least recent entry and reuse its slot
            for (int i = 0; i < ENTRIES; i++) begin
               if (cache_valid[i] && (victim < 0 || cache_rank[i] > worst)) begin
                  victim = i;
                  worst  = cache_rank[i];
               end
            end
            cache_key[victim]   = req.key;
            cache_value[victim] = req.write_value;
            promote_entry(victim, worst);
         end else begin
            for (int i = 0; i < ENTRIES; i++) begin
               if (slot < 0 && !cache_valid[i]) begin
                  slot = i;
               end
            end
            for (int i = 0; i < ENTRIES; i++) begin
               if (cache_valid[i]) begin
                  cache_rank[i]++;
               end
            end
            cache_key[slot]   = req.key;
            cache_value[slot] = req.write_value;
            cache_valid[slot] = 1'b1;
            cache_rank[slot]  = 0;
            cache_fill++;
         end
      end
      return rsp;
   endfunction

   function automatic lkv_req_type random_request(logic [KeyBits-1:0] key);
      lkv_req_type req;
      req.kind = $urandom_range(0, 1) ? KIND_PUT : KIND_GET;
      req.key  = key;
      case ($urandom_range(0, 9))
         0:       req.write_value = '0;
         1:       req.write_value = '1;
         default: req.write_value = ValueBits'($urandom_range(0, 16'hFFFF));
      endcase
      return req;
   endfunction

   task automatic push_request(logic kind, logic [KeyBits-1:0] key,
                               logic [ValueBits-1:0] value);
      cache_step_type step;
      step.kind            = STEP_REQUEST;
      step.req.kind        = kind;
      step.req.key         = key;
      step.req.write_value = value;
      step.cap             = '0;
      cache_steps.push_back(step);
   endtask

   task automatic push_control(step_kind_type kind, logic [CapBits-1:0] cap);
      cache_step_type step;
      step.kind = kind;
      step.req  = '0;
      step.cap  = cap;
      cache_steps.push_back(step);
   endtask

   // Drain, set a new capacity, then run random requests over a small key pool.
   task automatic push_phase(logic [CapBits-1:0] cap, int count, int pool_size);
      logic [KeyBits-1:0] pool[$];
      cache_step_type     step;
      push_control(STEP_DRAIN, '0);
      push_control(STEP_CONFIG, cap);
      pool.push_back('0);
      pool.push_back('1);
      for (int i = 0; i < pool_size; i++) begin
         pool.push_back(KeyBits'($urandom_range(0, 16'hFFFF)));
      end
      for (int i = 0; i < count; i++) begin
         step.kind = STEP_REQUEST;
         step.cap  = '0;
         if ($urandom_range(0, 99) < 85) begin
            step.req = random_request(pool[$urandom_range(0, pool.size() - 1)]);
         end else begin
            step.req = random_request(KeyBits'($urandom_range(0, 16'hFFFF)));
         end
         cache_steps.push_back(step);
      end
   endtask

   // Driver: the head of the step queue stays in place until it is accepted.
   always @(posedge clock) begin
      cache_step_type     head;
      logic               start_nx;
      lkv_req_type        req_nx;
      logic               we_nx;
      logic [CapBits-1:0] wdata_nx;
      if (reset) begin
         start     <= 1'b0;
         req_data  <= '0;
         csr_we    <= 1'b0;
         csr_wdata <= '0;
      end else begin
         start_nx = 1'b0;
         req_nx   = random_request(KeyBits'($urandom_range(0, 16'hFFFF)));
         we_nx    = 1'b0;
         wdata_nx = csr_wdata;
         if (start && !busy) begin
            void'(cache_steps.pop_front());
         end
         if (start && busy) begin
            start_nx = 1'b1;
            req_nx   = req_data;
         end else if (cache_steps.size() > 0) begin
            head = cache_steps[0];
            case (head.kind)
               STEP_REQUEST: begin
                  if (gap_left > 0) begin
                     gap_left--;
                  end else begin
                     start_nx = 1'b1;
                     req_nx   = head.req;
                     if (burst_left > 1) begin
                        burst_left--;
                     end else if ($urandom_range(0, 9) == 0) begin
                        burst_left = 64;
                        gap_left   = 0;
                     end else begin
                        burst_left = $urandom_range(1, 12);
                        gap_left   = $urandom_range(0, 5);
                     end
                  end
               end
               STEP_DRAIN: begin
                  // hold until every predicted response is in, then let it settle
                  if (!start && quiet) begin
                     settle_cnt++;
                     if (settle_cnt >= SETTLE_CYCLES) begin
                        settle_cnt = 0;
                        void'(cache_steps.pop_front());
                     end
                  end else begin
                     settle_cnt = 0;
                  end
               end
               STEP_CONFIG: begin
                  we_nx    = 1'b1;
                  wdata_nx = head.cap;
                  void'(cache_steps.pop_front());
               end
               default: ;
            endcase
         end
         start     <= start_nx;
         req_data  <= req_nx;
         csr_we    <= we_nx;
         csr_wdata <= wdata_nx;
      end
   end

   // Monitor: check responses first, then predict the request accepted at this edge.
   always @(posedge clock) begin
      lkv_rsp_type want;
      lkv_rsp_type got;
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) begin
            cache_valid[i] = 1'b0;
         end
         cache_fill = 0;
         cache_cap  = CAP_RESET;
         predicted_replies.delete();
         quiet <= 1'b1;
      end else begin
         if (rsp_strobe) begin
            if (predicted_replies.size() == 0) begin
               $error("unexpected response: hit=%0b read_value=0x%04h",
                      rsp_data.hit, rsp_data.read_value);
               n_errors++;
            end else begin
               want = predicted_replies.pop_front();
               got  = rsp_data;
               n_checked++;
               if (got.hit !== want.hit) begin
                  $error("hit mismatch: expected %0b, actual %0b", want.hit, got.hit);
                  n_errors++;
               end
               if (got.read_value !== want.read_value) begin
                  $error("read_value mismatch: expected 0x%04h, actual 0x%04h",
                         want.read_value, got.read_value);
                  n_errors++;
               end
            end
         end
         if (csr_we) begin
            cache_cap = csr_wdata;
            n_cfg++;
         end
         if (start && !busy) begin
            want = cache_access(req_data);
            predicted_replies.push_back(want);
            if (req_data.kind == KIND_PUT) begin
               n_puts++;
            end else begin
               n_gets++;
            end
            if (want.hit) begin
               n_hits++;
            end
         end
         quiet <= (predicted_replies.size() == 0);
      end
   end

   // Watchdog: end the run when nothing moves for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || csr_we) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("watchdog: no activity for %0d cycles", STALL_LIMIT);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      // empty store, reset capacity
      push_request(KIND_GET, 16'h0000, 16'hFFFF);
      push_request(KIND_PUT, 16'h0000, 16'hFFFF);
      push_request(KIND_GET, 16'h0000, 16'h0000);
      push_request(KIND_PUT, 16'hFFFF, 16'h0000);
      push_request(KIND_GET, 16'hFFFF, 16'hFFFF);
      push_request(KIND_PUT, 16'h0000, 16'h1234);
      push_request(KIND_GET, 16'h0000, 16'hAAAA);
      // capacity zero acts as one, and sits below the current occupancy
      push_control(STEP_DRAIN, '0);
      push_control(STEP_CONFIG, 5'd0);
      push_request(KIND_PUT, 16'h0101, 16'h5555);
      push_request(KIND_GET, 16'hFFFF, 16'h0000);
      push_request(KIND_GET, 16'h0000, 16'h0000);
      push_request(KIND_PUT, 16'h0202, 16'h8001);
      push_request(KIND_GET, 16'h0101, 16'h0000);
      push_request(KIND_GET, 16'h0202, 16'h0000);
      // capacity above the entry count acts as the entry count
      push_control(STEP_DRAIN, '0);
      push_control(STEP_CONFIG, 5'd31);
      push_request(KIND_PUT, 16'h8000, 16'h7FFF);
      push_request(KIND_PUT, 16'h0001, 16'hFFFE);
      push_request(KIND_GET, 16'h8000, 16'h0000);
      push_request(KIND_GET, 16'h0001, 16'h0000);
      push_request(KIND_GET, 16'h0202, 16'h0000);

      push_phase(5'd1,  40, 4);
      push_phase(5'd2,  40, 5);
      push_phase(5'd4,  40, 8);
      push_phase(5'd16, 60, 24);
      push_phase(5'd3,  40, 6);
      push_phase(5'd8,  40, 12);
      push_phase(5'd17, 40, 20);
      push_phase(5'd0,  30, 3);
      push_phase(5'd5,  40, 8);
      push_phase(5'd16, 50, 20);
      push_phase(5'd31, 30, 18);
      push_phase(5'd12, 40, 16);
      push_control(STEP_DRAIN, '0);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (cache_steps.size() != 0) begin
         @(posedge clock);
      end
      repeat (2 * SETTLE_CYCLES) @(posedge clock);
      if (predicted_replies.size() != 0) begin
         $error("%0d predicted responses never arrived", predicted_replies.size());
         n_errors++;
      end

      $display("Ran %0d requests (%0d gets, %0d puts, %0d hits), %0d responses checked,",
               n_gets + n_puts, n_gets, n_puts, n_hits, n_checked);
      $display("across %0d capacity writes including 0, 1, 16, 17 and 31.", n_cfg);
      if (n_errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ----- files.f -----
hw/rtl/lkv_pkg.sv
hw/rtl/lkv_lookup.sv
hw/rtl/lkv_store.sv
hw/rtl/lru_key_value_cache_top.sv
hw/rtl/lkv_checker.sv
tb/sv/lru_key_value_cache_top_tb.sv
